/* rtl/stls_pkg.sv */
// Shared types, codes and constants of the sound-triggered light sequencer.
// Used by every module under rtl; depends on nothing else.
`default_nettype none

package stls_pkg;

    // Fixed field widths.
    localparam int SAMPLE_W = 10;
    localparam int THR_W    = 10;
    localparam int TICK_W   = 16;
    localparam int CODE_W   = 2;
    localparam int INDEX_W  = 3;
    localparam int CFG_W    = 16;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 16;

    // Defaults for the top-level parameters.
    localparam int WINDOW_DEF     = 16;
    localparam int COUNT_BITS_DEF = 16;

    // Register reset values.
    localparam logic [THR_W-1:0]  THRESHOLD_RST  = 10'd512;
    localparam logic [TICK_W-1:0] GREEN_RST      = 16'd200;
    localparam logic [TICK_W-1:0] WAIT_RST       = 16'd500;
    localparam logic [TICK_W-1:0] FACE_HOLD_RST  = 16'd300;
    localparam logic [TICK_W-1:0] RED_RST        = 16'd400;

    // Register indexes on the configuration port.
    localparam logic [INDEX_W-1:0] REG_THRESHOLD = 3'd0;
    localparam logic [INDEX_W-1:0] REG_GREEN     = 3'd1;
    localparam logic [INDEX_W-1:0] REG_WAIT      = 3'd2;
    localparam logic [INDEX_W-1:0] REG_FACE_HOLD = 3'd3;
    localparam logic [INDEX_W-1:0] REG_RED       = 3'd4;

    // Phase codes as seen on the output.
    localparam logic [CODE_W-1:0] PHASE_GREEN   = 2'd0;
    localparam logic [CODE_W-1:0] PHASE_STANDBY = 2'd1;
    localparam logic [CODE_W-1:0] PHASE_FACE    = 2'd2;
    localparam logic [CODE_W-1:0] PHASE_RED     = 2'd3;

    // Picture codes.
    localparam logic [CODE_W-1:0] PIC_OFF   = 2'd0;
    localparam logic [CODE_W-1:0] PIC_GREEN = 2'd1;
    localparam logic [CODE_W-1:0] PIC_FACE  = 2'd2;
    localparam logic [CODE_W-1:0] PIC_RED   = 2'd3;

    typedef enum logic [3:0] {
        ST_GREEN   = 4'b0001,
        ST_STANDBY = 4'b0010,
        ST_FACE    = 4'b0100,
        ST_RED     = 4'b1000
    } state_t;

    // Commands from the sequencer to the sample window.
    typedef struct packed {
        logic load;
        logic clear;
    } win_ctl_t;

    // Phase lengths as held in the configuration registers.
    typedef struct packed {
        logic [TICK_W-1:0] green_ticks;
        logic [TICK_W-1:0] wait_ticks;
        logic [TICK_W-1:0] hold_ticks;
        logic [TICK_W-1:0] red_ticks;
    } cfg_t;

    // One result item.
    typedef struct packed {
        logic [SAMPLE_W-1:0] average_level;
        logic                display_update;
        logic [CODE_W-1:0]   display;
        logic [CODE_W-1:0]   phase;
    } result_t;

endpackage

`default_nettype wire

/* rtl/sound_triggered_light_sequencer.sv */
// Sound-triggered light sequencer, top level.
// Results go to the output register, or the skid register if that is full. One item per
// cycle while the skid register is free; each tick, window update included, runs in the
// same cycle in the phase sequencer and cell chain. Reset (rst_n, asynchronous, active
// low) clears the phase, counter, flags, window and buffers at once and loads register
// defaults. Depends on stls_pkg, stls_ctrl, stls_window, stls_cell and stls_outbuf.
`default_nettype none

module sound_triggered_light_sequencer
    import stls_pkg::*;
#(
    parameter int WINDOW     = WINDOW_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // Input items.
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // [9:0] envelope_sample, [15:10] zero
    // Result items.
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic      [OUT_TDATA_W-1:0] m_tdata,   // [1:0] phase, [3:2] display,
                                                   // [4] display_update,
                                                   // [14:5] average_level, [15] zero
    // Configuration writes.
    input  wire logic                   cfg_we,
    input  wire logic [INDEX_W-1:0]     cfg_index,
    input  wire logic [CFG_W-1:0]       cfg_data
);

    localparam int WIN_L = $clog2(WINDOW);
    localparam int SUM_W = SAMPLE_W + WIN_L;
    // The threshold is kept multiplied by the window length, so that the
    // voice decision compares the running sum directly.
    localparam logic [SUM_W-1:0] THR_SCALED_RST =
        SUM_W'(SUM_W'(THRESHOLD_RST) * SUM_W'(WINDOW));

    logic [SUM_W-1:0] thr_scaled_reg, thr_scaled_next;
    cfg_t             cfg_reg, cfg_next;

    always_comb
    begin
        thr_scaled_next = thr_scaled_reg;
        cfg_next        = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_THRESHOLD:
                    thr_scaled_next = SUM_W'(SUM_W'(cfg_data[THR_W-1:0]) * SUM_W'(WINDOW));
                REG_GREEN:     cfg_next.green_ticks = cfg_data[TICK_W-1:0];
                REG_WAIT:      cfg_next.wait_ticks  = cfg_data[TICK_W-1:0];
                REG_FACE_HOLD: cfg_next.hold_ticks  = cfg_data[TICK_W-1:0];
                REG_RED:       cfg_next.red_ticks   = cfg_data[TICK_W-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_scaled_reg      <= THR_SCALED_RST;
            cfg_reg.green_ticks <= GREEN_RST;
            cfg_reg.wait_ticks  <= WAIT_RST;
            cfg_reg.hold_ticks  <= FACE_HOLD_RST;
            cfg_reg.red_ticks   <= RED_RST;
        end
        else
        begin
            thr_scaled_reg <= thr_scaled_next;
            cfg_reg        <= cfg_next;
        end
    end

    // An item is taken whenever the skid register is free, so a finished
    // result waiting in the output register does not hold up the next tick.
    logic     fire;
    win_ctl_t win_ctl;
    logic     voice;
    result_t  result;
    result_t  out_res;

    assign fire = s_tvalid && s_tready;

    stls_ctrl #(
        .COUNT_BITS (COUNT_BITS)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .fire           (fire),
        .cfg            (cfg_reg),
        .voice          (voice),
        .win_ctl        (win_ctl),
        .phase          (result.phase),
        .display        (result.display),
        .display_update (result.display_update)
    );

    stls_window #(
        .WINDOW (WINDOW)
    ) u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (win_ctl),
        .sample     (s_tdata[SAMPLE_W-1:0]),
        .thr_scaled (thr_scaled_reg),
        .voice      (voice),
        .average    (result.average_level)
    );

    stls_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tdata = OUT_TDATA_W'(out_res);

endmodule

`default_nettype wire

/* rtl/stls_cell.sv */
// One cell of the sample window: holds a single envelope sample.
// Depends on stls_pkg.
`default_nettype none

module stls_cell
    import stls_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire win_ctl_t            ctl,
    input  wire logic [SAMPLE_W-1:0] d,
    output logic      [SAMPLE_W-1:0] q
);

    logic [SAMPLE_W-1:0] data_reg;
    logic [SAMPLE_W-1:0] data_next;

    // A clear empties the cell; a load takes the sample on d.
    always_comb
    begin
        data_next = data_reg;
        if (ctl.clear)
        begin
            data_next = '0;
        end
        else if (ctl.load)
        begin
            data_next = d;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg <= '0;
        end
        else
        begin
            data_reg <= data_next;
        end
    end

    assign q = data_reg;

endmodule

`default_nettype wire

/* rtl/stls_window.sv */
// Moving-average window: a chain of sample cells with a running sum,
// the voice compare and the average. Depends on stls_pkg and stls_cell.
`default_nettype none

module stls_window
    import stls_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF,
    localparam int WIN_L = $clog2(WINDOW),
    localparam int SUM_W = SAMPLE_W + WIN_L
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire win_ctl_t            ctl,
    input  wire logic [SAMPLE_W-1:0] sample,
    input  wire logic [SUM_W-1:0]    thr_scaled,
    output logic                     voice,
    output logic      [SAMPLE_W-1:0] average
);

    // Exact reciprocal for the division of the sum by WINDOW.
    localparam int SHIFT = SUM_W + WIN_L;
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << SHIFT) + WINDOW - 1) / WINDOW;
    localparam logic [SUM_W:0] RECIP = (SUM_W + 1)'(RECIP_FULL);
    localparam int PROD_W = 2 * SUM_W + 1;

    logic [SAMPLE_W-1:0] cell_q [WINDOW];
    logic [SUM_W-1:0]    sum_reg;
    logic [SUM_W-1:0]    sum_next;
    logic [PROD_W-1:0]   product;

    genvar gi;
    generate
        for (gi = 0; gi < WINDOW; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_head
                stls_cell u_cell (
                    .clk   (clk),
                    .rst_n (rst_n),
                    .ctl   (ctl),
                    .d     (sample),
                    .q     (cell_q[gi])
                );
            end
            else
            begin : g_body
                stls_cell u_cell (
                    .clk   (clk),
                    .rst_n (rst_n),
                    .ctl   (ctl),
                    .d     (cell_q[gi-1]),
                    .q     (cell_q[gi])
                );
            end
        end
    endgenerate

    // The oldest sample leaves from the far end of the chain as the new one
    // enters, so the sum never goes below the value leaving it.
    always_comb
    begin
        sum_next = sum_reg;
        if (ctl.clear)
        begin
            sum_next = '0;
        end
        else if (ctl.load)
        begin
            sum_next = sum_reg - SUM_W'(cell_q[WINDOW-1]) + SUM_W'(sample);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
        end
    end

    // The average reaches the threshold exactly when the sum reaches
    // threshold times WINDOW.
    assign voice   = (sum_next >= thr_scaled);
    assign product = PROD_W'(sum_next) * PROD_W'(RECIP);
    assign average = SAMPLE_W'(product >> SHIFT);

endmodule

`default_nettype wire

/* rtl/stls_ctrl.sv */
// Phase sequencer: phase state, tick counter, entry flags and the picture.
// Depends on stls_pkg.
`default_nettype none

module stls_ctrl
    import stls_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              fire,
    input  wire cfg_t              cfg,
    input  wire logic              voice,
    output win_ctl_t               win_ctl,
    output logic      [CODE_W-1:0] phase,
    output logic      [CODE_W-1:0] display,
    output logic                   display_update
);

    localparam int CMP_W = (COUNT_BITS > TICK_W) ? COUNT_BITS : TICK_W;

    state_t                state_reg,    state_next;
    logic [COUNT_BITS-1:0] count_reg,    count_next;
    logic                  ent_green_reg, ent_green_next;
    logic                  ent_sb_reg,   ent_sb_next;
    logic                  ent_face_reg, ent_face_next;
    logic                  ent_red_reg,  ent_red_next;
    logic                  heard_reg,    heard_next;
    logic [CODE_W-1:0]     pic_reg,      pic_next;
    logic                  upd;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
        sat_inc = (c == '1) ? c : c + 1'b1;
    endfunction

    function automatic logic at_limit(input logic [COUNT_BITS-1:0] c,
                                      input logic [TICK_W-1:0] lim);
        at_limit = (CMP_W'(c) >= CMP_W'(lim));
    endfunction

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ent_green_next = ent_green_reg;
        ent_sb_next    = ent_sb_reg;
        ent_face_next  = ent_face_reg;
        ent_red_next   = ent_red_reg;
        heard_next     = heard_reg;
        pic_next       = pic_reg;
        upd            = 1'b0;
        win_ctl        = '0;
        if (fire)
        begin
            unique case (state_reg)
                ST_GREEN:
                begin
                    if (!ent_green_reg)
                    begin
                        ent_green_next = 1'b1;
                        pic_next       = PIC_GREEN;
                        upd            = 1'b1;
                        count_next     = '0;
                        win_ctl.clear  = 1'b1;
                    end
                    count_next = sat_inc(count_next);
                    if (at_limit(count_next, cfg.green_ticks))
                    begin
                        ent_green_next = 1'b0;
                        state_next     = ST_STANDBY;
                        count_next     = '0;
                    end
                end
                ST_STANDBY:
                begin
                    if (!ent_sb_reg)
                    begin
                        ent_sb_next = 1'b1;
                        pic_next    = PIC_OFF;
                        upd         = 1'b1;
                    end
                    win_ctl.load = 1'b1;
                    if (voice)
                    begin
                        heard_next  = 1'b1;
                        count_next  = '0;
                        state_next  = ST_FACE;
                        ent_sb_next = 1'b0;
                    end
                    else
                    begin
                        count_next = sat_inc(count_reg);
                        if (at_limit(count_next, cfg.wait_ticks))
                        begin
                            ent_sb_next = 1'b0;
                            if (heard_reg)
                            begin
                                heard_next = 1'b0;
                                state_next = ST_GREEN;
                            end
                            else
                            begin
                                state_next = ST_RED;
                            end
                        end
                    end
                end
                ST_FACE:
                begin
                    if (!ent_face_reg)
                    begin
                        ent_face_next = 1'b1;
                        pic_next      = PIC_FACE;
                        upd           = 1'b1;
                    end
                    win_ctl.load = 1'b1;
                    if (voice)
                    begin
                        count_next = '0;
                    end
                    else
                    begin
                        count_next = sat_inc(count_reg);
                        if (at_limit(count_next, cfg.hold_ticks))
                        begin
                            ent_face_next = 1'b0;
                            state_next    = ST_STANDBY;
                            count_next    = '0;
                        end
                    end
                end
                ST_RED:
                begin
                    if (!ent_red_reg)
                    begin
                        ent_red_next = 1'b1;
                        pic_next     = PIC_RED;
                        upd          = 1'b1;
                        count_next   = '0;
                    end
                    count_next = sat_inc(count_next);
                    if (at_limit(count_next, cfg.red_ticks))
                    begin
                        ent_red_next = 1'b0;
                        state_next   = ST_GREEN;
                    end
                end
                default:
                begin
                    state_next = ST_GREEN;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_GREEN;
            count_reg     <= '0;
            ent_green_reg <= 1'b0;
            ent_sb_reg    <= 1'b0;
            ent_face_reg  <= 1'b0;
            ent_red_reg   <= 1'b0;
            heard_reg     <= 1'b0;
            pic_reg       <= PIC_OFF;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ent_green_reg <= ent_green_next;
            ent_sb_reg    <= ent_sb_next;
            ent_face_reg  <= ent_face_next;
            ent_red_reg   <= ent_red_next;
            heard_reg     <= heard_next;
            pic_reg       <= pic_next;
        end
    end

    // Phase code of the state after this tick.
    always_comb
    begin
        unique case (state_next)
            ST_GREEN:   phase = PHASE_GREEN;
            ST_STANDBY: phase = PHASE_STANDBY;
            ST_FACE:    phase = PHASE_FACE;
            ST_RED:     phase = PHASE_RED;
            default:    phase = PHASE_GREEN;
        endcase
    end

    assign display        = pic_next;
    assign display_update = upd;

endmodule

`default_nettype wire

/* rtl/stls_outbuf.sv */
// Two-entry output buffer: output register plus a skid register.
// Depends on stls_pkg.
`default_nettype none

module stls_outbuf
    import stls_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire result_t in_data,
    output logic         out_valid,
    input  wire logic    out_ready,
    output result_t      out_data
);

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_data_reg, out_data_next;
    result_t skid_data_reg, skid_data_next;

    assign in_ready = !skid_valid_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (out_valid_reg && out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        if (in_valid && !skid_valid_reg)
        begin
            if (!out_valid_next)
            begin
                out_data_next  = in_data;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_data_next  = in_data;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire
